// ----- design/assert_macros.svh -----
// Assertion helpers for the design files (included by the decoder)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Condition in the same cycle implies a consequence in that cycle
`define ASSERT_SAME(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("assertion failed: same-cycle implication");

// Condition implies a consequence in the following cycle
`define ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_SAME(label, pre, post)
`define ASSERT_NEXT(label, pre, post)

`endif

`endif

// ----- design/rotenc_pkg.sv -----
package rotenc_pkg;

   typedef logic [1:0] kind_type;
   typedef logic [7:0] count_type;
   typedef logic [1:0] csr_index_type;

   // Transaction kinds on the request channel
   localparam kind_type KIND_TICK     = 2'd0;
   localparam kind_type KIND_TAKE_CW  = 2'd1;
   localparam kind_type KIND_TAKE_CCW = 2'd2;

   // Configuration register indexes
   localparam csr_index_type CSR_COUNTER_ROOF    = 2'd0;
   localparam csr_index_type CSR_LEVEL_THRESHOLD = 2'd1;
   localparam csr_index_type CSR_DIRECTION_SWAP  = 2'd2;

   // Register values after reset
   localparam count_type ROOF_RESET      = 8'd8;
   localparam count_type THRESHOLD_RESET = 8'd4;
   localparam logic      SWAP_RESET      = 1'b0;

endpackage

// ----- design/rotenc_if.sv -----
// Request channel: tick with pin samples or a step take
interface rotenc_req_if;
   logic                valid;
   logic                ready;
   rotenc_pkg::kind_type kind;
   logic                clock_pin;
   logic                data_pin;

   modport source (output valid, output kind, output clock_pin, output data_pin,
                   input ready);
   modport sink   (input valid, input kind, input clock_pin, input data_pin,
                   output ready);
endinterface

// Result channel
interface rotenc_rsp_if;
   logic valid;
   logic ready;
   logic step_taken;
   logic clock_filtered;
   logic data_filtered;

   modport source (output valid, output step_taken, output clock_filtered,
                   output data_filtered, input ready);
   modport sink   (input valid, input step_taken, input clock_filtered,
                   input data_filtered, output ready);
endinterface

// Configuration write channel
interface rotenc_csr_if;
   logic                      valid;
   logic                      ready;
   rotenc_pkg::csr_index_type index;
   rotenc_pkg::count_type     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- design/rotary_encoder_filter_decoder.sv -----
// Each accepted request transaction has its result registered for the next cycle.
// Throughput: one transaction per cycle while the sink takes each result; the single
// result register is refilled in the same cycle that the sink takes its contents.
// Reset (synchronous, active high): pin counters, edge detector, pending flags
// and result valid clear; roof 8, threshold 4, direction swap 0.
`include "assert_macros.svh"

module rotary_encoder_filter_decoder (
   input logic          clock,
   input logic          reset,
   rotenc_req_if.sink   req_chan,
   rotenc_rsp_if.source rsp_chan,
   rotenc_csr_if.sink   csr_chan
);

   rotenc_pkg::count_type roof_ff, roof_in;
   rotenc_pkg::count_type thresh_ff, thresh_in;
   logic                  swap_ff, swap_in;

   rotenc_pkg::count_type clock_count_ff, clock_count_in;
   rotenc_pkg::count_type data_count_ff, data_count_in;
   logic                  last_clk_ff, last_clk_in;
   logic                  pend_cw_ff, pend_cw_in;
   logic                  pend_ccw_ff, pend_ccw_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  step_taken_ff, step_taken_in;
   logic                  clk_filt_ff, clk_filt_in;
   logic                  data_filt_ff, data_filt_in;

   logic                  req_accept;
   rotenc_pkg::count_type clock_next;
   rotenc_pkg::count_type data_next;
   logic                  clk_level;
   logic                  data_level;
   logic                  data_cw;

   // Accept whenever the result register is empty or drains this cycle
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   // Saturating integrators for both pins
   always_comb begin
      clock_next = clock_count_ff;
      if (req_chan.clock_pin) begin
         if (clock_count_ff < roof_ff) clock_next = clock_count_ff + 8'd1;
      end else if (clock_count_ff != 8'd0) begin
         clock_next = clock_count_ff - 8'd1;
      end
      data_next = data_count_ff;
      if (req_chan.data_pin) begin
         if (data_count_ff < roof_ff) data_next = data_count_ff + 8'd1;
      end else if (data_count_ff != 8'd0) begin
         data_next = data_count_ff - 8'd1;
      end
   end

   assign clk_level  = clock_next > thresh_ff;
   assign data_level = data_next > thresh_ff;
   assign data_cw    = swap_ff ? data_level : !data_level;

   // Update filter state, pending flags and the result
   always_comb begin
      clock_count_in = clock_count_ff;
      data_count_in  = data_count_ff;
      last_clk_in    = last_clk_ff;
      pend_cw_in     = pend_cw_ff;
      pend_ccw_in    = pend_ccw_ff;
      step_taken_in  = step_taken_ff;
      clk_filt_in    = clk_filt_ff;
      data_filt_in   = data_filt_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      if (req_accept) begin
         rsp_valid_in  = 1'b1;
         step_taken_in = 1'b0;
         clk_filt_in   = clock_count_ff > thresh_ff;
         data_filt_in  = data_count_ff > thresh_ff;
         case (req_chan.kind)
            rotenc_pkg::KIND_TICK: begin
               clock_count_in = clock_next;
               data_count_in  = data_next;
               last_clk_in    = clk_level;
               clk_filt_in    = clk_level;
               data_filt_in   = data_level;
               if (!last_clk_ff && clk_level) begin
                  if (data_cw) pend_cw_in  = 1'b1;
                  else         pend_ccw_in = 1'b1;
               end
            end
            rotenc_pkg::KIND_TAKE_CW: begin
               step_taken_in = pend_cw_ff;
               pend_cw_in    = 1'b0;
            end
            rotenc_pkg::KIND_TAKE_CCW: begin
               step_taken_in = pend_ccw_ff;
               pend_ccw_in   = 1'b0;
            end
            default: begin
               // unused kind: report levels, change nothing
            end
         endcase
      end
   end

   // Decode configuration writes; drop writes beyond the register list
   always_comb begin
      roof_in   = roof_ff;
      thresh_in = thresh_ff;
      swap_in   = swap_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            rotenc_pkg::CSR_COUNTER_ROOF:    roof_in   = csr_chan.data;
            rotenc_pkg::CSR_LEVEL_THRESHOLD: thresh_in = csr_chan.data;
            rotenc_pkg::CSR_DIRECTION_SWAP:  swap_in   = csr_chan.data[0];
            default: begin
            end
         endcase
      end
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         roof_ff        <= rotenc_pkg::ROOF_RESET;
         thresh_ff      <= rotenc_pkg::THRESHOLD_RESET;
         swap_ff        <= rotenc_pkg::SWAP_RESET;
         clock_count_ff <= 8'd0;
         data_count_ff  <= 8'd0;
         last_clk_ff    <= 1'b0;
         pend_cw_ff     <= 1'b0;
         pend_ccw_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         roof_ff        <= roof_in;
         thresh_ff      <= thresh_in;
         swap_ff        <= swap_in;
         clock_count_ff <= clock_count_in;
         data_count_ff  <= data_count_in;
         last_clk_ff    <= last_clk_in;
         pend_cw_ff     <= pend_cw_in;
         pend_ccw_ff    <= pend_ccw_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      step_taken_ff <= step_taken_in;
      clk_filt_ff   <= clk_filt_in;
      data_filt_ff  <= data_filt_in;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.step_taken     = step_taken_ff;
   assign rsp_chan.clock_filtered = clk_filt_ff;
   assign rsp_chan.data_filtered  = data_filt_ff;

   `ASSERT_NEXT(a_accept_fills_result, req_accept, rsp_valid_ff)
   `ASSERT_NEXT(a_tick_takes_nothing,
      req_accept && req_chan.kind == rotenc_pkg::KIND_TICK, !step_taken_ff)
   `ASSERT_NEXT(a_take_cw_clears,
      req_accept && req_chan.kind == rotenc_pkg::KIND_TAKE_CW, !pend_cw_ff)
   `ASSERT_SAME(a_stall_blocks_accept, rsp_valid_ff && !rsp_chan.ready, !req_accept)

endmodule
